// ===== src/cdnd_pkg.sv =====
// Package with register indexes, field widths and reset values for the needle driver.
package cdnd_pkg;

   localparam int unsigned CourseWidth   = 9;
   localparam int unsigned StepWidth     = 7;
   localparam int unsigned GainWidth     = 4;
   localparam int unsigned PixelWidth    = 8;
   localparam int unsigned DevWidth      = 8;
   localparam int unsigned EncWidth      = 2;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_ENCODER_STEP      = 2'd0;
   localparam csr_index_type CSR_PIXELS_PER_DEGREE = 2'd1;
   localparam csr_index_type CSR_NEEDLE_CENTER     = 2'd2;
   localparam csr_index_type CSR_NEEDLE_MAX        = 2'd3;

   localparam logic [StepWidth-1:0]  STEP_RESET   = 7'd5;
   localparam logic [GainWidth-1:0]  GAIN_RESET   = 4'd5;
   localparam logic [PixelWidth-1:0] CENTER_RESET = 8'd40;
   localparam logic [PixelWidth-1:0] MAX_RESET    = 8'd80;

   // Quadrature codes seen by the direction lock.
   localparam logic [EncWidth-1:0] ENC_IDLE = 2'd0;
   localparam logic [EncWidth-1:0] ENC_A    = 2'd1;
   localparam logic [EncWidth-1:0] ENC_B    = 2'd2;

endpackage

// ===== src/course_deviation_needle_driver.sv =====
// Course deviation needle driver: course knob, TO/FROM fold and needle slew in one pass.

// One update beat is accepted per clock cycle unless a result waiting on rsp_ready holds a
// beat in the input register. A beat is captured in that register, worked through one pass of
// add, fold, 8x4 multiply and clamp logic into the result register, and offered from there. The course, encoder
// lock, deviation, TO flag and needle position carry from beat to beat and are updated
// as each beat leaves the input register, so back-to-back beats see each other's
// effect. Configuration writes take effect at once and are expected only while idle.
module course_deviation_needle_driver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cdnd_pkg::EncWidth-1:0]    req_encoder_bits,
   input  logic [cdnd_pkg::CourseWidth-1:0] req_true_radial,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cdnd_pkg::CourseWidth-1:0] rsp_course_setting,
   output logic                             rsp_to_mode,
   output logic signed [cdnd_pkg::DevWidth-1:0] rsp_deviation,
   output logic [cdnd_pkg::PixelWidth-1:0]  rsp_target_position,
   output logic [cdnd_pkg::PixelWidth-1:0]  rsp_needle_position,
   input  logic                             csr_we,
   input  logic [cdnd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [cdnd_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import cdnd_pkg::*;

   // Configuration registers.
   logic [StepWidth-1:0]  step_ff;
   logic [GainWidth-1:0]  gain_ff;
   logic [PixelWidth-1:0] center_ff;
   logic [PixelWidth-1:0] max_ff;

   // Input stage.
   logic                   in_valid_ff;
   logic [EncWidth-1:0]    in_bits_ff;
   logic [CourseWidth-1:0] in_radial_ff;

   // Carried state.
   logic [CourseWidth-1:0]     course_ff,  course_in;
   logic [EncWidth-1:0]        lock_ff,    lock_in;
   logic signed [DevWidth-1:0] dev_ff,     dev_in;
   logic                       to_ff,      to_in;
   logic [PixelWidth-1:0]      needle_ff,  needle_in;

   // Result stage.
   logic                   out_valid_ff;
   logic [CourseWidth-1:0] out_course_ff;
   logic                   out_to_ff;
   logic signed [DevWidth-1:0] out_dev_ff;
   logic [PixelWidth-1:0]  out_target_ff, target_in;
   logic [PixelWidth-1:0]  out_needle_ff;

   logic advance;
   logic [EncWidth-1:0] lock_pre;
   logic down_detent, up_detent;
   logic [CourseWidth:0] course_dn, course_up;
   logic signed [10:0] diff_raw, diff_fold;
   logic signed [12:0] product, target_raw;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      // Direction lock and detent detection.
      lock_pre    = (lock_ff == ENC_IDLE || in_bits_ff == ENC_IDLE) ? in_bits_ff : lock_ff;
      down_detent = (in_bits_ff == ENC_B) && (lock_pre == ENC_A);
      up_detent   = (in_bits_ff == ENC_A) && (lock_pre == ENC_B);
      lock_in     = (down_detent || up_detent) ? ENC_IDLE : lock_pre;

      course_dn = {1'b0, course_ff} - {3'b000, step_ff};
      course_up = {1'b0, course_ff} + {3'b000, step_ff};
      course_in = course_ff;
      if (down_detent) begin
         // A borrow out of the top bit means the course went below zero.
         course_in = course_dn[CourseWidth] ? CourseWidth'(course_dn + 10'd360)
                                            : course_dn[CourseWidth-1:0];
      end else if (up_detent) begin
         course_in = (course_up > 10'd359) ? '0 : course_up[CourseWidth-1:0];
      end

      diff_raw = $signed({2'b00, course_in}) - $signed({2'b00, in_radial_ff});
      if (diff_raw < -11'sd180) begin
         diff_fold = diff_raw + 11'sd360;
      end else if (diff_raw > 11'sd180) begin
         diff_fold = diff_raw - 11'sd360;
      end else begin
         diff_fold = diff_raw;
      end

      // At exactly plus or minus ninety the previous indication is held.
      dev_in = dev_ff;
      to_in  = to_ff;
      if (diff_fold > 11'sd90) begin
         to_in  = 1'b0;
         dev_in = DevWidth'(11'sd180 - diff_fold);
      end else if (diff_fold < -11'sd90) begin
         to_in  = 1'b0;
         dev_in = DevWidth'(-11'sd180 - diff_fold);
      end else if (diff_fold != 11'sd90 && diff_fold != -11'sd90) begin
         to_in  = 1'b1;
         dev_in = DevWidth'(diff_fold);
      end

      product    = $signed({{5{dev_in[DevWidth-1]}}, dev_in}) * $signed({9'd0, gain_ff});
      target_raw = product + $signed({5'b00000, center_ff});
      if (target_raw > $signed({5'b00000, max_ff})) begin
         target_in = max_ff;
      end else if (target_raw < 13'sd0) begin
         target_in = '0;
      end else begin
         target_in = target_raw[PixelWidth-1:0];
      end

      if (target_in > needle_ff) begin
         needle_in = needle_ff + 8'd1;
      end else if (target_in < needle_ff) begin
         needle_in = needle_ff - 8'd1;
      end else begin
         needle_in = needle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         gain_ff   <= GAIN_RESET;
         center_ff <= CENTER_RESET;
         max_ff    <= MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENCODER_STEP:      step_ff   <= csr_wdata[StepWidth-1:0];
            CSR_PIXELS_PER_DEGREE: gain_ff   <= csr_wdata[GainWidth-1:0];
            CSR_NEEDLE_CENTER:     center_ff <= csr_wdata;
            CSR_NEEDLE_MAX:        max_ff    <= csr_wdata;
            default:               ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         course_ff    <= '0;
         lock_ff      <= ENC_IDLE;
         dev_ff       <= '0;
         to_ff        <= 1'b0;
         needle_ff    <= CENTER_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               course_ff <= course_in;
               lock_ff   <= lock_in;
               dev_ff    <= dev_in;
               to_ff     <= to_in;
               needle_ff <= needle_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_bits_ff   <= req_encoder_bits;
         in_radial_ff <= req_true_radial;
      end
      if (advance && in_valid_ff) begin
         out_course_ff <= course_in;
         out_to_ff     <= to_in;
         out_dev_ff    <= dev_in;
         out_target_ff <= target_in;
         out_needle_ff <= needle_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_course_setting  = out_course_ff;
   assign rsp_to_mode         = out_to_ff;
   assign rsp_deviation       = out_dev_ff;
   assign rsp_target_position = out_target_ff;
   assign rsp_needle_position = out_needle_ff;

`ifndef SYNTHESIS
   a_course_range : assert property (@(posedge clock) disable iff (reset)
      course_ff < 9'd360)
      else $error("course left its 0 to 359 range");

   a_dev_range : assert property (@(posedge clock) disable iff (reset)
      dev_ff <= 8'sd90 && dev_ff >= -8'sd90)
      else $error("deviation outside plus or minus ninety");

   a_needle_slew : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (needle_ff == $past(needle_ff) ||
                         needle_ff == $past(needle_ff) + 8'd1 ||
                         needle_ff == $past(needle_ff) - 8'd1))
      else $error("needle moved more than one pixel in a cycle");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff |=> out_valid_ff)
      else $error("beat left the input stage without a result");
`endif

endmodule

// ===== tb/sv/needle_driver_checker.sv =====
// Checker that predicts every needle driver result and compares it with the result beats.
module needle_driver_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [cdnd_pkg::EncWidth-1:0]        req_encoder_bits,
   input  logic [cdnd_pkg::CourseWidth-1:0]     req_true_radial,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [cdnd_pkg::CourseWidth-1:0]     rsp_course_setting,
   input  logic                                 rsp_to_mode,
   input  logic signed [cdnd_pkg::DevWidth-1:0] rsp_deviation,
   input  logic [cdnd_pkg::PixelWidth-1:0]      rsp_target_position,
   input  logic [cdnd_pkg::PixelWidth-1:0]      rsp_needle_position,
   input  logic                                 csr_we,
   input  cdnd_pkg::csr_index_type              csr_index,
   input  logic [cdnd_pkg::CsrDataWidth-1:0]    csr_wdata,
   output int                                   open_beats,
   output int                                   mismatches,
   output int                                   readings_checked
);
   import cdnd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_TURN    = 360;
   localparam int LAST_DEGREE  = 359;
   localparam int HALF_TURN    = 180;
   localparam int QUARTER_TURN = 90;

   typedef struct packed {
      logic [CourseWidth-1:0] course;
      logic                   to_mode;
      logic [DevWidth-1:0]    deviation;
      logic [PixelWidth-1:0]  target;
      logic [PixelWidth-1:0]  needle;
   } needle_reading_type;

   needle_reading_type readings_q[$];

   int step_deg;
   int gain_ppd;
   int center_px;
   int max_px;

   int            course_deg;
   int            deviation_deg;
   int            needle_px;
   logic [EncWidth-1:0] lock_code;
   logic          to_flag;

   function automatic int field_mismatch(string field, int want, int got);
      if (want == got) return 0;
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      int                 diff;
      int                 target;
      needle_reading_type want;
      if (reset) begin
         step_deg         = int'(STEP_RESET);
         gain_ppd         = int'(GAIN_RESET);
         center_px        = int'(CENTER_RESET);
         max_px           = int'(MAX_RESET);
         course_deg       = 0;
         lock_code        = ENC_IDLE;
         deviation_deg    = 0;
         to_flag          = 1'b0;
         needle_px        = int'(CENTER_RESET);
         mismatches       = 0;
         readings_checked = 0;
         readings_q.delete();
         open_beats <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENCODER_STEP:      step_deg  = int'(csr_wdata[StepWidth-1:0]);
               CSR_PIXELS_PER_DEGREE: gain_ppd  = int'(csr_wdata[GainWidth-1:0]);
               CSR_NEEDLE_CENTER:     center_px = int'(csr_wdata[PixelWidth-1:0]);
               CSR_NEEDLE_MAX:        max_px    = int'(csr_wdata[PixelWidth-1:0]);
               default:               ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (readings_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result beat with no reading expected, course %0d needle %0d",
                        $time, rsp_course_setting, rsp_needle_position);
            end else begin
               want = readings_q.pop_front();
               mismatches += field_mismatch("course_setting", int'(want.course),
                                            int'(rsp_course_setting));
               mismatches += field_mismatch("to_mode", int'(want.to_mode), int'(rsp_to_mode));
               mismatches += field_mismatch("deviation", int'($signed(want.deviation)),
                                            int'(rsp_deviation));
               mismatches += field_mismatch("target_position", int'(want.target),
                                            int'(rsp_target_position));
               mismatches += field_mismatch("needle_position", int'(want.needle),
                                            int'(rsp_needle_position));
               readings_checked++;
            end
         end

         if (req_valid && req_ready) begin
            // The lock remembers the first quadrature code; the opposite code completes a detent.
            if (lock_code == ENC_IDLE || req_encoder_bits == ENC_IDLE)
               lock_code = req_encoder_bits;
            if (req_encoder_bits == ENC_B && lock_code == ENC_A) begin
               course_deg -= step_deg;
               if (course_deg < 0) course_deg += FULL_TURN;
               lock_code = ENC_IDLE;
            end else if (req_encoder_bits == ENC_A && lock_code == ENC_B) begin
               course_deg += step_deg;
               if (course_deg > LAST_DEGREE) course_deg = 0;
               lock_code = ENC_IDLE;
            end

            diff = course_deg - int'(req_true_radial);
            if (diff < -HALF_TURN) diff += FULL_TURN;
            else if (diff > HALF_TURN) diff -= FULL_TURN;

            // Exactly on the quarter turn neither branch fires and the last indication is held.
            if (diff > QUARTER_TURN || diff < -QUARTER_TURN) begin
               to_flag       = 1'b0;
               deviation_deg = (diff > QUARTER_TURN) ? HALF_TURN - diff : -HALF_TURN - diff;
            end else if (diff < QUARTER_TURN && diff > -QUARTER_TURN) begin
               to_flag       = 1'b1;
               deviation_deg = diff;
            end

            target = deviation_deg * gain_ppd + center_px;
            if (target > max_px) target = max_px;
            else if (target < 0) target = 0;

            if (target > needle_px) needle_px++;
            else if (target < needle_px) needle_px--;

            want.course    = CourseWidth'(course_deg);
            want.to_mode   = to_flag;
            want.deviation = DevWidth'(deviation_deg);
            want.target    = PixelWidth'(target);
            want.needle    = PixelWidth'(needle_px);
            readings_q.push_back(want);
         end

         open_beats <= readings_q.size();
      end
   end

endmodule

// ===== tb/sv/course_deviation_needle_driver_test.sv =====
// Top of the needle driver testbench: clock, reset, stimulus, flow control and verdict.
module course_deviation_needle_driver_test;
   import cdnd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [EncWidth-1:0] ENC_BOTH = 2'd3;
   localparam int RANDOM_PHASES    = 8;
   localparam int BEATS_PER_PHASE  = 192;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_TWO_OF_THREE,
      READY_RANDOM,
      READY_SPARSE
   } ready_mode_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [EncWidth-1:0]        req_encoder_bits = ENC_IDLE;
   logic [CourseWidth-1:0]     req_true_radial  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [CourseWidth-1:0]     rsp_course_setting;
   logic                       rsp_to_mode;
   logic signed [DevWidth-1:0] rsp_deviation;
   logic [PixelWidth-1:0]      rsp_target_position;
   logic [PixelWidth-1:0]      rsp_needle_position;
   logic                       csr_we           = 1'b0;
   csr_index_type              csr_index        = CSR_ENCODER_STEP;
   logic [CsrDataWidth-1:0]    csr_wdata        = '0;

   int open_beats;
   int mismatches;
   int readings_checked;

   int             burst_left       = 0;
   int             beats_sent       = 0;
   int             settings_applied = 0;
   int unsigned    stall_tick       = 0;
   ready_mode_type stall_mode       = READY_ALWAYS;

   course_deviation_needle_driver u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_encoder_bits    (req_encoder_bits),
      .req_true_radial     (req_true_radial),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_course_setting  (rsp_course_setting),
      .rsp_to_mode         (rsp_to_mode),
      .rsp_deviation       (rsp_deviation),
      .rsp_target_position (rsp_target_position),
      .rsp_needle_position (rsp_needle_position),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   needle_driver_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_encoder_bits    (req_encoder_bits),
      .req_true_radial     (req_true_radial),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_course_setting  (rsp_course_setting),
      .rsp_to_mode         (rsp_to_mode),
      .rsp_deviation       (rsp_deviation),
      .rsp_target_position (rsp_target_position),
      .rsp_needle_position (rsp_needle_position),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .open_beats          (open_beats),
      .mismatches          (mismatches),
      .readings_checked    (readings_checked)
   );

   always #6 clock = ~clock;

   // The receiver switches between randomly chosen stall patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_tick <= 0;
         stall_mode <= READY_ALWAYS;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 97 == 96) stall_mode <= ready_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            READY_ALWAYS:       rsp_ready <= 1'b1;
            READY_TWO_OF_THREE: rsp_ready <= (stall_tick % 3) != 2;
            READY_RANDOM:       rsp_ready <= $urandom_range(0, 3) != 0;
            default:            rsp_ready <= (stall_tick % 16) < 4;
         endcase
      end
   end

   // Sends one update beat; a new burst may begin after an idle gap.
   task automatic send_beat(input logic [EncWidth-1:0] bits,
                            input logic [CourseWidth-1:0] radial);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_encoder_bits <= bits;
      req_true_radial  <= radial;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_beats != 0);
      burst_left = 0;
   endtask

   task automatic program_registers(input logic [CsrDataWidth-1:0] step,
                                    input logic [CsrDataWidth-1:0] gain,
                                    input logic [CsrDataWidth-1:0] center,
                                    input logic [CsrDataWidth-1:0] top_px);
      csr_index_type           regs[4];
      logic [CsrDataWidth-1:0] values[4];
      regs[0]   = CSR_ENCODER_STEP;
      regs[1]   = CSR_PIXELS_PER_DEGREE;
      regs[2]   = CSR_NEEDLE_CENTER;
      regs[3]   = CSR_NEEDLE_MAX;
      values[0] = step;
      values[1] = gain;
      values[2] = center;
      values[3] = top_px;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      int                   drift;
      int                   pick;
      logic [EncWidth-1:0]  bits;
      logic [CourseWidth-1:0] radial;
      logic [EncWidth-1:0]  knob_seq[$];
      drift = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings: detents both ways with wrap at 0 and 360,
      // the held indication on both quarter turns, FROM on both sides, a stuck lock and
      // radials beyond 359.
      send_beat(ENC_IDLE, 9'd0);
      send_beat(ENC_B, 9'd0);
      send_beat(ENC_A, 9'd0);
      send_beat(ENC_IDLE, 9'd5);
      send_beat(ENC_A, 9'd90);
      send_beat(ENC_B, 9'd95);
      send_beat(ENC_A, 9'd90);
      send_beat(ENC_B, 9'd270);
      send_beat(ENC_IDLE, 9'd265);
      send_beat(ENC_B, 9'd0);
      send_beat(ENC_A, 9'd180);
      send_beat(ENC_BOTH, 9'd359);
      send_beat(ENC_A, 9'd511);
      send_beat(ENC_B, 9'd360);
      send_beat(ENC_IDLE, 9'd0);
      send_beat(ENC_BOTH, 9'd256);
      send_beat(ENC_IDLE, 9'd181);
      send_beat(ENC_IDLE, 9'd100);
      send_beat(ENC_IDLE, 9'd356);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: program_registers(8'd1, 8'd1, 8'd0, 8'd0);
            1: program_registers(8'd90, 8'd15, 8'd255, 8'd255);
            2: program_registers(8'd0, 8'd0, 8'd200, 8'd100);
            3: program_registers(8'hFF, 8'hFF, 8'd0, 8'd255);
            default: program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // Mostly complete detents in either direction, with some stray codes mixed in.
            if (knob_seq.size() == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 65) begin
                  if ($urandom_range(0, 1) == 1) begin
                     knob_seq.push_back(ENC_B);
                     knob_seq.push_back(ENC_A);
                  end else begin
                     knob_seq.push_back(ENC_A);
                     knob_seq.push_back(ENC_B);
                  end
                  knob_seq.push_back(ENC_IDLE);
               end else if (pick < 85) begin
                  knob_seq.push_back(EncWidth'($urandom_range(0, 3)));
               end else begin
                  knob_seq.push_back(ENC_IDLE);
               end
            end
            bits = knob_seq.pop_front();

            // A slowly drifting radial sweeps the fold through every boundary value.
            pick = $urandom_range(0, 99);
            if (pick < 85) drift = (drift + $urandom_range(0, 2) + 359) % 360;
            else if (pick < 95) drift = $urandom_range(0, 359);
            radial = (pick >= 95) ? CourseWidth'($urandom_range(360, 511))
                                  : CourseWidth'(drift);
            send_beat(bits, radial);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d update beats under %0d register settings; %0d results compared.",
               beats_sent, settings_applied, readings_checked);
      $display("Settings spanned zero and full-scale step and gain, and center above max.");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected.", open_beats);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
